FILE: design/vfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared types and constants for the voxel face visibility block.
// ----------------------------------------------------------------------------
package vfv_pkg;

  localparam int COORD_W    = 4;
  localparam int DEF_SIZE_X = 16;
  localparam int DEF_SIZE_Y = 16;
  localparam int DEF_SIZE_Z = 16;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic               solid_in;
  } in_item_t;

  typedef struct packed {
    logic solid_out;
    logic face_neg_z;
    logic face_pos_z;
    logic face_neg_y;
    logic face_pos_y;
    logic face_neg_x;
    logic face_pos_x;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

FILE: design/voxel_face_visibility.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_visibility
// Occupancy map of one voxel chunk with per-cell face visibility queries.
//
//   channel | direction | payload           | transaction
//   in_     | input     | vfv_pkg::in_item_t  | write (no result) or query
//   out_    | output    | vfv_pkg::out_item_t | one per query
//
// A write produces no result. A query makes one read of the cell and
// six neighbor reads through the single port of the occupancy RAM.
// The next item is taken in the last cycle of a query when the output
// register is free or drains in that cycle; otherwise input stalls.
// Reset clears control state only; the map is undefined until written.
// ----------------------------------------------------------------------------
module voxel_face_visibility #(
  parameter int SIZE_X = vfv_pkg::DEF_SIZE_X,
  parameter int SIZE_Y = vfv_pkg::DEF_SIZE_Y,
  parameter int SIZE_Z = vfv_pkg::DEF_SIZE_Z
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vfv_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vfv_pkg::out_item_t out_data
);
  import vfv_pkg::*;

  localparam int AW    = $clog2(SIZE_X) + $clog2(SIZE_Y) + $clog2(SIZE_Z);
  localparam int DEPTH = 2 ** AW;

  logic          out_full_r;
  out_item_t     out_data_r;
  logic          out_free;
  res_t          res;
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [0:0]    ram_wdata;
  logic [0:0]    ram_rdata;

  assign out_free  = !out_full_r || !out_stall;
  assign out_valid = out_full_r;
  assign out_data  = out_data_r;

  vfv_seq #(
    .SIZE_X (SIZE_X),
    .SIZE_Y (SIZE_Y),
    .SIZE_Z (SIZE_Z)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_free  (out_free),
    .res       (res),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  vfv_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (res.valid) begin
      out_full_r <= 1'b1;
    end else if (!out_stall) begin
      out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.item;
    end
  end

endmodule

FILE: design/vfv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module vfv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: design/vfv_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_seq
// Access sequencer: writes occupancy, reads a queried cell and its six
// neighbors one per cycle and assembles the face flags.
// ----------------------------------------------------------------------------
module vfv_seq #(
  parameter int SIZE_X = vfv_pkg::DEF_SIZE_X,
  parameter int SIZE_Y = vfv_pkg::DEF_SIZE_Y,
  parameter int SIZE_Z = vfv_pkg::DEF_SIZE_Z,
  localparam int AW    = $clog2(SIZE_X) + $clog2(SIZE_Y) + $clog2(SIZE_Z)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vfv_pkg::in_item_t in_data,
  input  logic              out_free,
  output vfv_pkg::res_t     res,
  output logic              ram_en,
  output logic              ram_we,
  output logic [AW-1:0]     ram_addr,
  output logic [0:0]        ram_wdata,
  input  logic [0:0]        ram_rdata
);
  import vfv_pkg::*;

  localparam int XW = $clog2(SIZE_X);
  localparam int YW = $clog2(SIZE_Y);
  localparam int ZW = $clog2(SIZE_Z);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  localparam logic [2:0] STEP_FIRST = 3'd1;
  localparam logic [2:0] STEP_NBR   = 3'd6;
  localparam logic [2:0] STEP_LAST  = 3'd7;

  logic [1:0]    state_r, state_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [ZW-1:0] z_r;
  logic          inside_r;
  logic [5:0]    edge_r;
  logic [5:0]    open_r;
  logic          solid_r;

  logic [XW-1:0] ix;
  logic [YW-1:0] iy;
  logic [ZW-1:0] iz;
  logic          in_inside;
  logic [5:0]    in_edge;
  logic          in_acc;
  logic          in_query;
  logic          done_now;
  logic [2:0]    nbr_sel;
  logic [2:0]    cap_idx;
  logic          cap_open;
  logic [5:0]    open_cur;
  logic [AW-1:0] nbr_addr;

  always_comb begin
    ix = XW'(in_data.cell_x);
    iy = YW'(in_data.cell_y);
    iz = ZW'(in_data.cell_z);
    in_inside = (int'(in_data.cell_x) < SIZE_X) && (int'(in_data.cell_y) < SIZE_Y) &&
                (int'(in_data.cell_z) < SIZE_Z);
    in_edge[0] = (iz == '0);
    in_edge[1] = (iz == ZW'(SIZE_Z - 1));
    in_edge[2] = (iy == '0);
    in_edge[3] = (iy == YW'(SIZE_Y - 1));
    in_edge[4] = (ix == '0);
    in_edge[5] = (ix == XW'(SIZE_X - 1));

    done_now = ((state_r == S_RUN) && (cnt_r == STEP_LAST)) || (state_r == S_WAIT);
    in_stall = !((state_r == S_IDLE) || (done_now && out_free));
    in_acc   = in_valid && !in_stall;
    in_query = in_acc && (in_data.action == ACT_QUERY);

    nbr_sel  = 3'(cnt_r - STEP_FIRST);
    cap_idx  = 3'(cnt_r - 3'd2);
    cap_open = edge_r[cap_idx] | ~ram_rdata[0];
  end

  always_comb begin
    nbr_addr = {x_r, y_r, z_r};
    unique case (nbr_sel)
      3'd0:    nbr_addr = {x_r, y_r, ZW'(z_r - ZW'(1))};
      3'd1:    nbr_addr = {x_r, y_r, ZW'(z_r + ZW'(1))};
      3'd2:    nbr_addr = {x_r, YW'(y_r - YW'(1)), z_r};
      3'd3:    nbr_addr = {x_r, YW'(y_r + YW'(1)), z_r};
      3'd4:    nbr_addr = {XW'(x_r - XW'(1)), y_r, z_r};
      3'd5:    nbr_addr = {XW'(x_r + XW'(1)), y_r, z_r};
      default: nbr_addr = {x_r, y_r, z_r};
    endcase
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = {ix, iy, iz};
    ram_wdata = in_data.solid_in;
    if (in_acc) begin
      ram_en = in_query || in_inside;
      ram_we = !in_query;
    end else if ((state_r == S_RUN) && (cnt_r <= STEP_NBR)) begin
      ram_en   = 1'b1;
      ram_addr = nbr_addr;
    end
  end

  always_comb begin
    open_cur = open_r;
    if (state_r == S_RUN) begin
      open_cur[5] = edge_r[5] | ~ram_rdata[0];
    end
    res.valid           = done_now && out_free;
    res.item.solid_out  = solid_r;
    res.item.face_neg_z = solid_r & open_cur[0];
    res.item.face_pos_z = solid_r & open_cur[1];
    res.item.face_neg_y = solid_r & open_cur[2];
    res.item.face_pos_y = solid_r & open_cur[3];
    res.item.face_neg_x = solid_r & open_cur[4];
    res.item.face_pos_x = solid_r & open_cur[5];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_query) begin
          state_nxt = S_RUN;
          cnt_nxt   = STEP_FIRST;
        end
      end
      S_RUN: begin
        if (cnt_r != STEP_LAST) begin
          cnt_nxt = 3'(cnt_r + 3'd1);
        end else if (!out_free) begin
          state_nxt = S_WAIT;
        end else if (in_query) begin
          cnt_nxt = STEP_FIRST;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          if (in_query) begin
            state_nxt = S_RUN;
            cnt_nxt   = STEP_FIRST;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_query) begin
      x_r      <= ix;
      y_r      <= iy;
      z_r      <= iz;
      inside_r <= in_inside;
      edge_r   <= in_edge;
    end
    if (state_r == S_RUN) begin
      if (cnt_r == STEP_FIRST) begin
        solid_r <= inside_r & ram_rdata[0];
      end else begin
        open_r[cap_idx] <= cap_open;
      end
    end
  end

endmodule

FILE: design/vfv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_checker
// Port-level checks for voxel_face_visibility, bound to the top level.
// ----------------------------------------------------------------------------
module vfv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input vfv_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input vfv_pkg::out_item_t out_data
);
  import vfv_pkg::*;

  logic query_acc;
  assign query_acc = in_valid && !in_stall && (in_data.action == ACT_QUERY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> in_stall)
    else $error("transaction accepted right after a query");

  a_query_len: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |-> ##6 in_stall)
    else $error("query finished before its neighbor reads");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind voxel_face_visibility vfv_checker u_vfv_checker (.*);
